/* rtl/huffman_table_encoder_defines.svh */
// Assertion macros for the table-driven Huffman encoder.
// Needs a clock and a reset signal in the scope of the module that asserts.
`ifndef HUFFMAN_TABLE_ENCODER_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define HTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition implies a result in the next cycle
`define HTE_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/huff_enc_pkg.sv */
// Package for the table-driven Huffman encoder: command codes, field widths
// and parameter defaults. No dependencies.
package huff_enc_pkg;

   localparam int MAX_CODE_LEN_DEFAULT = 24;
   localparam int SYMBOL_COUNT_DEFAULT = 256;

   localparam int CMD_W      = 2;
   localparam int SYMBOL_W   = 8;
   localparam int CODE_W     = 24;
   localparam int LEN_W      = 5;
   localparam int BYTE_W     = 8;
   localparam int PEND_W     = 7;
   localparam int CNT_W      = 3;
   localparam int ACC_W      = PEND_W + CODE_W;
   localparam int TOTAL_W    = 5;
   localparam int ENTRY_W    = LEN_W + CODE_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

endpackage

/* rtl/huffman_table_encoder.sv */
// Table-driven Huffman encoder, MSB first. A load writes the table. An encode reads the
// table, merges the code with pending bits and runs the byte loop that puts each byte in the
// output register; a flush with pending bits goes straight to the byte loop. Output stalls
// hold the byte loop. A new item is taken once the last byte, if any, of the previous one
// is in the output register. Synchronous reset clears the table valid bits, so every entry
// reads as length zero. Depends on huff_enc_pkg and huffman_table_encoder_defines.svh.
`include "huffman_table_encoder_defines.svh"

module huffman_table_encoder #(
   parameter int MAX_CODE_LEN = huff_enc_pkg::MAX_CODE_LEN_DEFAULT,
   parameter int SYMBOL_COUNT = huff_enc_pkg::SYMBOL_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cmd[1:0], symbol[9:2], code_bits[33:10], code_len[38:34], zero[39]
   input  logic [huff_enc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_byte[7:0]
   output logic [huff_enc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int IDX_W     = $clog2(SYMBOL_COUNT);
   localparam int LEN_LIMIT = (MAX_CODE_LEN < huff_enc_pkg::CODE_W) ?
                              MAX_CODE_LEN : huff_enc_pkg::CODE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   state_type                             state_ff, state_in;
   logic [huff_enc_pkg::ENTRY_W-1:0]      code_table_ff [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]               valid_ff;
   logic [huff_enc_pkg::ENTRY_W-1:0]      rd_data_ff;
   logic                                  rd_valid_ff;
   logic [huff_enc_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic [huff_enc_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic [huff_enc_pkg::PEND_W-1:0]       pend_bits_ff, pend_bits_in;
   logic [huff_enc_pkg::CNT_W-1:0]        pend_cnt_ff, pend_cnt_in;
   logic                                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [huff_enc_pkg::BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                                  rsp_last_ff, rsp_last_in;

   huff_enc_pkg::cmd_type                 cmd;
   logic [huff_enc_pkg::SYMBOL_W-1:0]     sym;
   logic [huff_enc_pkg::CODE_W-1:0]       in_code;
   logic [huff_enc_pkg::LEN_W-1:0]        in_len;
   logic [huff_enc_pkg::LEN_W-1:0]        len_sat;
   logic [huff_enc_pkg::CODE_W:0]         code_mask;
   logic [huff_enc_pkg::ENTRY_W-1:0]      wr_entry;
   logic                                  accept;
   logic                                  in_range;
   logic                                  do_write;
   logic                                  do_read;
   logic [IDX_W-1:0]                      idx;

   logic [huff_enc_pkg::ENTRY_W-1:0]      lk_entry;
   logic [huff_enc_pkg::LEN_W-1:0]        lk_len;
   logic [huff_enc_pkg::CODE_W-1:0]       lk_code;
   logic [huff_enc_pkg::ACC_W-1:0]        lk_acc;
   logic [huff_enc_pkg::TOTAL_W-1:0]      lk_total;
   logic [huff_enc_pkg::BYTE_W-1:0]       flush_byte;

   logic                                  out_free;
   logic [huff_enc_pkg::TOTAL_W-1:0]      em_sh;
   logic [huff_enc_pkg::BYTE_W-1:0]       em_byte;
   logic                                  em_last;
   logic [huff_enc_pkg::BYTE_W-1:0]       rem_mask;

   assign cmd      = huff_enc_pkg::cmd_type'(req_tdata[1:0]);
   assign sym      = req_tdata[9:2];
   assign in_code  = req_tdata[33:10];
   assign in_len   = req_tdata[38:34];
   assign accept   = req_tvalid && req_tready;
   assign in_range = {1'b0, sym} < 9'(SYMBOL_COUNT);
   assign idx      = sym[IDX_W-1:0];

   assign len_sat   = (in_len > huff_enc_pkg::LEN_W'(LEN_LIMIT)) ?
                      huff_enc_pkg::LEN_W'(LEN_LIMIT) : in_len;
   assign code_mask = (25'd1 << len_sat) - 25'd1;
   assign wr_entry  = {len_sat, in_code & code_mask[huff_enc_pkg::CODE_W-1:0]};
   assign do_write  = accept && (cmd == huff_enc_pkg::CMD_LOAD) && in_range;
   assign do_read   = accept && (cmd == huff_enc_pkg::CMD_ENCODE) && in_range;

   assign lk_entry   = rd_valid_ff ? rd_data_ff : '0;
   assign lk_len     = lk_entry[huff_enc_pkg::ENTRY_W-1:huff_enc_pkg::CODE_W];
   assign lk_code    = lk_entry[huff_enc_pkg::CODE_W-1:0];
   assign lk_acc     = (huff_enc_pkg::ACC_W'(pend_bits_ff) << lk_len) |
                       huff_enc_pkg::ACC_W'(lk_code);
   assign lk_total   = huff_enc_pkg::TOTAL_W'(pend_cnt_ff) + lk_len;
   assign flush_byte = {pend_bits_ff, 1'b0} << (3'd7 - pend_cnt_ff);

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign em_sh    = total_ff - 5'd8;
   assign em_byte  = huff_enc_pkg::BYTE_W'(acc_ff >> em_sh);
   assign em_last  = em_sh < 5'd8;
   assign rem_mask = (8'd1 << em_sh[2:0]) - 8'd1;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (do_write) begin
         code_table_ff[idx] <= wr_entry;
      end
      if (do_read) begin
         rd_data_ff <= code_table_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (do_write) begin
            valid_ff[idx] <= 1'b1;
         end
         if (accept) begin
            rd_valid_ff <= do_read && valid_ff[idx];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      total_in      = total_ff;
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  huff_enc_pkg::CMD_ENCODE: begin
                     if (in_range) begin
                        state_in = ST_LOOKUP;
                     end
                  end
                  huff_enc_pkg::CMD_FLUSH: begin
                     if (pend_cnt_ff != '0) begin
                        acc_in   = huff_enc_pkg::ACC_W'(flush_byte);
                        total_in = 5'd8;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (lk_len == '0) begin
               state_in = ST_IDLE;
            end else if (lk_total >= 5'd8) begin
               acc_in   = lk_acc;
               total_in = lk_total;
               state_in = ST_EMIT;
            end else begin
               pend_bits_in = lk_acc[huff_enc_pkg::PEND_W-1:0];
               pend_cnt_in  = lk_total[huff_enc_pkg::CNT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_byte_in   = em_byte;
               rsp_last_in   = em_last;
               total_in      = em_sh;
               if (em_last) begin
                  pend_bits_in = acc_ff[huff_enc_pkg::PEND_W-1:0] &
                                 rem_mask[huff_enc_pkg::PEND_W-1:0];
                  pend_cnt_in  = em_sh[huff_enc_pkg::CNT_W-1:0];
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_bits_ff  <= '0;
         pend_cnt_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   `HTE_ASSERT(a_emit_has_byte, (state_ff != ST_EMIT) || (total_ff >= 5'd8),
      "byte loop entered with fewer than eight bits")
   `HTE_ASSERT_NEXT(a_flush_emits,
      accept && (cmd == huff_enc_pkg::CMD_FLUSH) && (pend_cnt_ff != '0),
      state_ff == ST_EMIT, "flush with pending bits did not start the byte loop")
   `HTE_ASSERT_NEXT(a_zero_len_quiet, (state_ff == ST_LOOKUP) && (lk_len == '0),
      $stable(pend_cnt_ff) && $stable(pend_bits_ff) && (state_ff == ST_IDLE),
      "zero-length code changed the accumulator")
   `HTE_ASSERT_NEXT(a_last_ends_item, (state_ff == ST_EMIT) && out_free && em_last,
      (state_ff == ST_IDLE) && rsp_tvalid_ff && rsp_last_ff,
      "final byte not marked last or loop not left")

endmodule

/* tb/huffman_table_encoder_checker.sv */
// Result checker for huffman_table_encoder: watches both stream channels, predicts the
// output bytes of every accepted item and compares them in order.
// Depends on huff_enc_pkg.
`timescale 1ns / 100ps

module huffman_table_encoder_checker
   import huff_enc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // cmd[1:0], symbol[9:2], code_bits[33:10], code_len[38:34], zero[39]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_byte[7:0]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   output int                    mismatch_count,
   output int                    pending_results
);

   localparam int LEN_LIMIT = (MAX_CODE_LEN_DEFAULT < CODE_W) ? MAX_CODE_LEN_DEFAULT : CODE_W;
   localparam int EXP_DEPTH = 64;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } out_item_type;

   out_item_type      exp_fifo [EXP_DEPTH];
   int                exp_head  = 0;
   int                exp_tail  = 0;
   int                exp_count = 0;
   logic [LEN_W-1:0]  len_table [SYMBOL_COUNT_DEFAULT];
   logic [CODE_W-1:0] code_table [SYMBOL_COUNT_DEFAULT];
   logic [PEND_W-1:0] pend_bits;
   logic [CNT_W-1:0]  pend_cnt;
   int                errors = 0;

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("%0t: huffman_table_encoder mismatch: %s", $time, msg);
      end
   endfunction

   function automatic void store_expected(input out_item_type item);
      if (exp_count == EXP_DEPTH) begin
         note_error("expected item buffer overflow");
      end else begin
         exp_fifo[exp_tail] = item;
         exp_tail = (exp_tail + 1) % EXP_DEPTH;
         exp_count++;
      end
   endfunction

   task automatic predict_item(input logic [REQ_DATA_W-1:0] data);
      logic [CMD_W-1:0]    cmd;
      logic [SYMBOL_W-1:0] sym;
      logic [CODE_W-1:0]   code;
      logic [LEN_W-1:0]    len;
      logic [ACC_W-1:0]    acc;
      logic [BYTE_W-1:0]   flushed;
      int                  total;
      out_item_type        item;
      cmd  = data[CMD_W-1:0];
      sym  = data[CMD_W +: SYMBOL_W];
      code = data[CMD_W+SYMBOL_W +: CODE_W];
      len  = data[CMD_W+SYMBOL_W+CODE_W +: LEN_W];
      case (cmd)
         CMD_LOAD: begin
            if (len > LEN_LIMIT) len = LEN_W'(LEN_LIMIT);
            code = CODE_W'(({8'd0, code}) & ((32'd1 << len) - 32'd1));
            len_table[sym]  = len;
            code_table[sym] = code;
         end
         CMD_ENCODE: begin
            len  = len_table[sym];
            code = code_table[sym];
            if (len != 0) begin
               acc   = ({{CODE_W{1'b0}}, pend_bits} << len) | {{PEND_W{1'b0}}, code};
               total = int'(pend_cnt) + int'(len);
               while (total >= 8) begin
                  item.out_byte = BYTE_W'(acc >> (total - 8));
                  item.last     = (total - 8) < 8;
                  store_expected(item);
                  total -= 8;
               end
               pend_bits = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
               pend_cnt  = CNT_W'(total);
            end
         end
         CMD_FLUSH: begin
            if (pend_cnt != 0) begin
               flushed       = {1'b0, pend_bits} << (4'd8 - pend_cnt);
               item.out_byte = flushed;
               item.last     = 1'b1;
               store_expected(item);
               pend_bits = '0;
               pend_cnt  = '0;
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      out_item_type want;
      if (reset) begin
         foreach (len_table[i]) begin
            len_table[i]  = '0;
            code_table[i] = '0;
         end
         pend_bits = '0;
         pend_cnt  = '0;
         exp_head  = 0;
         exp_tail  = 0;
         exp_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (exp_count == 0) begin
               note_error($sformatf("unexpected item byte %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = exp_fifo[exp_head];
               exp_head = (exp_head + 1) % EXP_DEPTH;
               exp_count--;
               if (want.out_byte !== rsp_tdata || want.last !== rsp_tlast) begin
                  note_error($sformatf("expected byte %h last %b, got byte %h last %b",
                                       want.out_byte, want.last, rsp_tdata, rsp_tlast));
               end
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tdata);
      end
      mismatch_count  <= errors;
      pending_results <= exp_count;
   end

endmodule

/* tb/huffman_table_encoder_tb.sv */
// Testbench top for huffman_table_encoder: drives load, encode and flush items, stalls
// the output side, and gives the verdict from huffman_table_encoder_checker.
// Depends on huff_enc_pkg, huffman_table_encoder and huffman_table_encoder_checker.
`timescale 1ns / 100ps

module huffman_table_encoder_tb;
   import huff_enc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int END_CYCLES     = 20;
   localparam int CODED_DEPTH    = 256;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int                    checker_errors;
   int                    pending_results;
   int                    quiet_cycles = 0;
   logic                  steady_flow  = 1'b0;
   logic                  holdoff_on   = 1'b0;
   logic [SYMBOL_W-1:0]   coded_symbols [CODED_DEPTH];
   int                    coded_count  = 0;

   huffman_table_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   huffman_table_encoder_checker byte_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (checker_errors),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("huffman_table_encoder regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit stall_done;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_on && !stall_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            stall_done = 1'b1;
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(99) >= 10);
         end
      end
   end

   function automatic void note_coded(input logic [SYMBOL_W-1:0] sym);
      if (coded_count < CODED_DEPTH) begin
         coded_symbols[coded_count] = sym;
         coded_count++;
      end
   endfunction

   function automatic logic [SYMBOL_W-1:0] pick_coded();
      return coded_symbols[$urandom_range(coded_count - 1)];
   endfunction

   task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SYMBOL_W-1:0] sym,
                        input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
      while (!steady_flow && !holdoff_on && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, len, code, sym, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic load_random_entry();
      logic [SYMBOL_W-1:0] sym;
      logic [LEN_W-1:0]    len;
      int                  pick;
      sym  = SYMBOL_W'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 8) len = '0;
      else if (pick < 16) len = LEN_W'($urandom_range(31, 25));
      else if (pick < 60) len = LEN_W'($urandom_range(8, 1));
      else len = LEN_W'($urandom_range(24, 9));
      note_coded(sym);
      offer(CMD_LOAD, sym, CODE_W'($urandom), len);
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         load_random_entry();
      end else if (pick < 20) begin
         offer(CMD_FLUSH, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end else if (pick < 24) begin
         offer(CMD_UNUSED, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end else if (pick < 30) begin
         offer(CMD_ENCODE, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end else begin
         offer(CMD_ENCODE, pick_coded(), CODE_W'($urandom), LEN_W'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(CMD_ENCODE, 8'h00, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_FLUSH, 8'h00, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_UNUSED, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_LOAD, 8'hFF, 24'hFFFFFF, 5'd24);
      offer(CMD_LOAD, 8'h00, 24'h000000, 5'd1);
      offer(CMD_LOAD, 8'h55, CODE_W'($urandom), 5'd31);
      offer(CMD_LOAD, 8'hAA, 24'hFFFFFF, 5'd3);
      offer(CMD_LOAD, 8'h01, 24'h000005, 5'd3);
      offer(CMD_LOAD, 8'h01, CODE_W'($urandom), 5'd0);
      offer(CMD_LOAD, 8'h80, 24'h0000A5, 5'd8);
      offer(CMD_LOAD, 8'h7F, 24'h000055, 5'd7);
      offer(CMD_ENCODE, 8'h00, 24'hFFFFFF, 5'd31);
      offer(CMD_ENCODE, 8'hFF, 24'h000000, 5'd0);
      offer(CMD_ENCODE, 8'hAA, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'h01, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'h55, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_FLUSH, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_FLUSH, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'hFF, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'h7F, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_FLUSH, SYMBOL_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'h80, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'h7F, CODE_W'($urandom), LEN_W'($urandom));
      offer(CMD_ENCODE, 8'h00, CODE_W'($urandom), LEN_W'($urandom));
      coded_count = 0;
      note_coded(8'hFF);
      note_coded(8'h00);
      note_coded(8'h55);
      note_coded(8'hAA);
      note_coded(8'h80);
      note_coded(8'h7F);

      repeat (12) load_random_entry();
      repeat (16) send_random_item();
      drain();

      offer(CMD_LOAD, 8'hFF, CODE_W'($urandom), 5'd24);
      holdoff_on = 1'b1;
      repeat (20) begin
         if ($urandom_range(3) == 0) begin
            offer(CMD_ENCODE, pick_coded(), CODE_W'($urandom), LEN_W'($urandom));
         end else begin
            offer(CMD_ENCODE, 8'hFF, CODE_W'($urandom), LEN_W'($urandom));
         end
      end
      holdoff_on = 1'b0;
      drain();

      steady_flow = 1'b1;
      repeat (20) send_random_item();
      steady_flow = 1'b0;
      repeat (10) send_random_item();

      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (checker_errors == 0 && pending_results == 0) begin
         $display("huffman_table_encoder regression: pass");
      end else begin
         $display("huffman_table_encoder regression: fail");
      end
      $finish;
   end

endmodule
